// ===== src/vkt_pkg.sv =====
package vkt_pkg;

  localparam int KEY_SLOTS_DEF = 16;
  localparam int VERSIONS_DEF  = 8;
  localparam int INFO_BITS_DEF = 16;

  localparam int KEY_W        = 32;
  localparam int VER_FIELD_W  = 4;
  localparam int INFO_FIELD_W = 16;

  localparam int IN_DATA_W  = 56;
  localparam int OUT_DATA_W = 24;

  typedef enum logic [1:0] {
    OP_INSERT = 2'd0,
    OP_QUERY  = 2'd1,
    OP_FETCH  = 2'd2,
    OP_DELETE = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_NOKEY = 2'd1,
    ST_NOVER = 2'd2,
    ST_FULL  = 2'd3
  } status_t;

  typedef struct packed {
    logic create;
    logic bump;
  } cell_upd_t;

endpackage

// ===== src/vkt_cell.sv =====
module vkt_cell #(
  parameter int LV_W = 4
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic signed [vkt_pkg::KEY_W-1:0] key_i,
  input  logic                           prev_valid_i,
  input  vkt_pkg::cell_upd_t             upd_i,
  output logic                           valid_o,
  output logic                           hit_o,
  output logic                           free_o,
  output logic [LV_W-1:0]                latest_o
);

  logic signed [vkt_pkg::KEY_W-1:0] tag_r;
  logic                             valid_r;
  logic [LV_W-1:0]                  latest_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (upd_i.create) begin
      valid_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (upd_i.create) begin
      tag_r    <= key_i;
      latest_r <= LV_W'(1);
    end else if (upd_i.bump) begin
      latest_r <= latest_r + LV_W'(1);
    end
  end

  // Slots fill in order and are never freed, so the first free cell is the one
  // whose left neighbour is in use.
  assign valid_o  = valid_r;
  assign hit_o    = valid_r && (tag_r == key_i);
  assign free_o   = !valid_r && prev_valid_i;
  assign latest_o = latest_r;

endmodule

// ===== src/vkt_vmem.sv =====
module vkt_vmem #(
  parameter int DEPTH     = 128,
  parameter int INFO_BITS = 16,
  localparam int ADDR_W   = $clog2(DEPTH)
) (
  input  logic                 clk,
  input  logic                 wr_info_en,
  input  logic                 wr_busy_en,
  input  logic [ADDR_W-1:0]    wr_addr,
  input  logic [INFO_BITS-1:0] wr_info,
  input  logic                 wr_busy,
  input  logic                 rd_en,
  input  logic [ADDR_W-1:0]    rd_addr,
  output logic [INFO_BITS-1:0] rd_info,
  output logic                 rd_busy
);

  logic [INFO_BITS-1:0] info_mem [DEPTH];
  logic                 busy_mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_info_en) begin
      info_mem[wr_addr] <= wr_info;
    end
    if (rd_en) begin
      rd_info <= info_mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (wr_busy_en) begin
      busy_mem[wr_addr] <= wr_busy;
    end
    if (rd_en) begin
      rd_busy <= busy_mem[rd_addr];
    end
  end

endmodule

// ===== src/versioned_key_table.sv =====
// One operation at a time: the slot cells compare the key, the version memory is
// written or read, its registered read data is formatted into the output register,
// and only then is the next input transaction taken. A waiting result does not
// block a new input transaction, but holds the following result until the output
// register is free.
// Reset empties every slot; the version memory is not cleared.
module versioned_key_table #(
  parameter int KEY_SLOTS = vkt_pkg::KEY_SLOTS_DEF,
  parameter int VERSIONS  = vkt_pkg::VERSIONS_DEF,
  parameter int INFO_BITS = vkt_pkg::INFO_BITS_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_tvalid,
  output logic                             in_tready,
  // op [1:0], key [33:2], version [37:34], info_handle [53:38], zero fill
  input  logic [vkt_pkg::IN_DATA_W-1:0]    in_tdata,
  output logic                             out_tvalid,
  input  logic                             out_tready,
  // status [1:0], version_out [5:2], info_out [21:6], busy_out [22], zero fill
  output logic [vkt_pkg::OUT_DATA_W-1:0]   out_tdata
);

  localparam int SLOT_W = $clog2(KEY_SLOTS);
  localparam int LV_W   = $clog2(VERSIONS + 1);
  localparam int DEPTH  = KEY_SLOTS * VERSIONS;
  localparam int ADDR_W = $clog2(DEPTH);
  localparam int CMP_W  = (LV_W > vkt_pkg::VER_FIELD_W) ? LV_W : vkt_pkg::VER_FIELD_W;

  typedef enum logic [1:0] {
    S_IDLE,
    S_MATCH,
    S_MEM,
    S_RESP
  } state_t;

  state_t                             state_r;
  vkt_pkg::op_t                       op_r;
  logic signed [vkt_pkg::KEY_W-1:0]   key_r;
  logic [vkt_pkg::VER_FIELD_W-1:0]    ver_r;
  logic [INFO_BITS-1:0]               info_r;
  logic                               hit_r;
  logic [SLOT_W-1:0]                  slot_r;
  logic [SLOT_W-1:0]                  free_slot_r;
  logic                               full_r;
  logic [LV_W-1:0]                    latest_r;
  vkt_pkg::status_t                   status_r;
  logic [LV_W-1:0]                    vout_r;
  logic                               fetch_r;
  logic                               out_valid_r;
  logic [vkt_pkg::OUT_DATA_W-1:0]     out_data_r;

  logic [KEY_SLOTS-1:0]               valid_vec;
  logic [KEY_SLOTS-1:0]               hit_vec;
  logic [KEY_SLOTS-1:0]               free_vec;
  logic [LV_W-1:0]                    cell_latest [KEY_SLOTS];
  vkt_pkg::cell_upd_t                 cell_upd [KEY_SLOTS];

  logic [SLOT_W-1:0]                  hit_slot;
  logic [SLOT_W-1:0]                  free_slot;
  logic [LV_W-1:0]                    hit_latest;

  logic                               do_create;
  logic                               do_bump;
  logic [SLOT_W-1:0]                  upd_slot;
  logic                               wr_info_en;
  logic                               wr_busy_en;
  logic                               wr_busy;
  logic [ADDR_W-1:0]                  wr_addr;
  logic                               rd_en;
  logic [ADDR_W-1:0]                  rd_addr;
  logic [INFO_BITS-1:0]               rd_info;
  logic                               rd_busy;
  vkt_pkg::status_t                   status_nxt;
  logic [LV_W-1:0]                    vout_nxt;
  logic                               fetch_nxt;

  logic [ADDR_W-1:0]                  hit_base;
  logic                               lv_full;
  logic                               ver_ok;
  logic                               out_free;

  for (genvar i = 0; i < KEY_SLOTS; i++) begin : g_cell
    logic prev_valid;
    if (i == 0) begin : g_first
      assign prev_valid = 1'b1;
    end else begin : g_rest
      assign prev_valid = valid_vec[i-1];
    end

    assign cell_upd[i].create = do_create && (upd_slot == SLOT_W'(i));
    assign cell_upd[i].bump   = do_bump && (upd_slot == SLOT_W'(i));

    vkt_cell #(
      .LV_W(LV_W)
    ) u_cell (
      .clk         (clk),
      .rst_n       (rst_n),
      .key_i       (key_r),
      .prev_valid_i(prev_valid),
      .upd_i       (cell_upd[i]),
      .valid_o     (valid_vec[i]),
      .hit_o       (hit_vec[i]),
      .free_o      (free_vec[i]),
      .latest_o    (cell_latest[i])
    );
  end

  always_comb begin
    hit_slot   = '0;
    free_slot  = '0;
    hit_latest = '0;
    for (int i = 0; i < KEY_SLOTS; i++) begin
      if (hit_vec[i]) begin
        hit_slot   = hit_slot | SLOT_W'(i);
        hit_latest = hit_latest | cell_latest[i];
      end
      if (free_vec[i]) begin
        free_slot = free_slot | SLOT_W'(i);
      end
    end
  end

  assign hit_base = ADDR_W'(slot_r) * ADDR_W'(VERSIONS);
  assign lv_full  = (latest_r == LV_W'(VERSIONS));
  assign ver_ok   = (CMP_W'(ver_r) != '0) && (CMP_W'(ver_r) <= CMP_W'(latest_r));

  always_comb begin
    do_create  = 1'b0;
    do_bump    = 1'b0;
    upd_slot   = slot_r;
    wr_info_en = 1'b0;
    wr_busy_en = 1'b0;
    wr_busy    = 1'b0;
    wr_addr    = hit_base + ADDR_W'(latest_r);
    rd_en      = 1'b0;
    rd_addr    = hit_base + ADDR_W'(ver_r - 4'd1);
    status_nxt = vkt_pkg::ST_OK;
    vout_nxt   = '0;
    fetch_nxt  = 1'b0;
    unique case (op_r)
      vkt_pkg::OP_INSERT: begin
        if (hit_r) begin
          vout_nxt = latest_r;
          if (lv_full) begin
            status_nxt = vkt_pkg::ST_FULL;
          end else begin
            do_bump    = 1'b1;
            wr_info_en = 1'b1;
            wr_busy_en = 1'b1;
            wr_busy    = 1'b1;
            vout_nxt   = latest_r + LV_W'(1);
          end
        end else if (full_r) begin
          status_nxt = vkt_pkg::ST_FULL;
        end else begin
          do_create  = 1'b1;
          upd_slot   = free_slot_r;
          wr_info_en = 1'b1;
          wr_busy_en = 1'b1;
          wr_busy    = 1'b1;
          wr_addr    = ADDR_W'(free_slot_r) * ADDR_W'(VERSIONS);
          vout_nxt   = LV_W'(1);
        end
      end
      vkt_pkg::OP_QUERY: begin
        if (hit_r) begin
          vout_nxt = latest_r;
        end else begin
          status_nxt = vkt_pkg::ST_NOKEY;
        end
      end
      vkt_pkg::OP_FETCH: begin
        if (!hit_r) begin
          status_nxt = vkt_pkg::ST_NOKEY;
        end else begin
          vout_nxt = latest_r;
          if (ver_ok) begin
            rd_en     = 1'b1;
            fetch_nxt = 1'b1;
          end else begin
            status_nxt = vkt_pkg::ST_NOVER;
          end
        end
      end
      vkt_pkg::OP_DELETE: begin
        if (!hit_r) begin
          status_nxt = vkt_pkg::ST_NOKEY;
        end else begin
          vout_nxt   = latest_r;
          wr_busy_en = 1'b1;
          wr_addr    = hit_base + ADDR_W'(latest_r - LV_W'(1));
        end
      end
    endcase
    if (state_r != S_MEM) begin
      do_create  = 1'b0;
      do_bump    = 1'b0;
      wr_info_en = 1'b0;
      wr_busy_en = 1'b0;
      rd_en      = 1'b0;
    end
  end

  vkt_vmem #(
    .DEPTH    (DEPTH),
    .INFO_BITS(INFO_BITS)
  ) u_vmem (
    .clk       (clk),
    .wr_info_en(wr_info_en),
    .wr_busy_en(wr_busy_en),
    .wr_addr   (wr_addr),
    .wr_info   (info_r),
    .wr_busy   (wr_busy),
    .rd_en     (rd_en),
    .rd_addr   (rd_addr),
    .rd_info   (rd_info),
    .rd_busy   (rd_busy)
  );

  assign out_free = !out_valid_r || out_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      op_r        <= vkt_pkg::OP_QUERY;
      out_valid_r <= 1'b0;
    end else begin
      if (out_valid_r && out_tready && state_r != S_RESP) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        S_IDLE: begin
          if (in_tvalid) begin
            op_r    <= vkt_pkg::op_t'(in_tdata[1:0]);
            key_r   <= in_tdata[33:2];
            ver_r   <= in_tdata[37:34];
            info_r  <= INFO_BITS'(in_tdata[53:38]);
            state_r <= S_MATCH;
          end
        end
        S_MATCH: begin
          hit_r       <= |hit_vec;
          slot_r      <= hit_slot;
          latest_r    <= hit_latest;
          free_slot_r <= free_slot;
          full_r      <= valid_vec[KEY_SLOTS-1];
          state_r     <= S_MEM;
        end
        S_MEM: begin
          status_r <= status_nxt;
          vout_r   <= vout_nxt;
          fetch_r  <= fetch_nxt;
          state_r  <= S_RESP;
        end
        S_RESP: begin
          if (out_free) begin
            out_valid_r <= 1'b1;
            out_data_r  <= {1'b0,
                            fetch_r && rd_busy,
                            fetch_r ? vkt_pkg::INFO_FIELD_W'(rd_info)
                                    : vkt_pkg::INFO_FIELD_W'(0),
                            vkt_pkg::VER_FIELD_W'(vout_r),
                            status_r};
            state_r     <= S_IDLE;
          end
        end
      endcase
    end
  end

  assign in_tready  = (state_r == S_IDLE);
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  a_accept_starts_match: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> state_r == S_MATCH)
    else $error("accepted transaction did not start a key match");

  a_unique_hit: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_MATCH |-> $onehot0(hit_vec))
    else $error("key found in more than one slot");

  a_slots_prefix: assert property (@(posedge clk) disable iff (!rst_n)
    (valid_vec & (valid_vec + KEY_SLOTS'(1))) == '0)
    else $error("occupied slots are not a contiguous prefix");

  a_single_free: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0(free_vec) && (valid_vec[KEY_SLOTS-1] || $onehot(free_vec)))
    else $error("first free slot is not unique");

endmodule

// ===== test/vkt_checker.sv =====
module vkt_checker (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_tvalid,
  input  logic                           in_tready,
  input  logic [vkt_pkg::IN_DATA_W-1:0]  in_tdata,
  input  logic                           out_tvalid,
  input  logic                           out_tready,
  input  logic [vkt_pkg::OUT_DATA_W-1:0] out_tdata,
  output int                             errors,
  output int                             pending
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int SLOTS = vkt_pkg::KEY_SLOTS_DEF;
  localparam int DEPTH = vkt_pkg::VERSIONS_DEF;

  typedef struct packed {
    vkt_pkg::status_t                 status;
    logic [vkt_pkg::VER_FIELD_W-1:0]  ver;
    logic [vkt_pkg::INFO_FIELD_W-1:0] info;
    logic                             busy;
  } table_result_t;

  logic [vkt_pkg::KEY_W-1:0]        slot_key [SLOTS];
  bit                               slot_used [SLOTS];
  logic [vkt_pkg::VER_FIELD_W-1:0]  slot_top [SLOTS];
  logic [vkt_pkg::INFO_FIELD_W-1:0] ver_info [SLOTS][DEPTH];
  bit                               ver_busy [SLOTS][DEPTH];

  table_result_t awaited_q [$];

  task automatic apply_op(input vkt_pkg::op_t op, input logic [vkt_pkg::KEY_W-1:0] k,
                          input logic [vkt_pkg::VER_FIELD_W-1:0] v,
                          input logic [vkt_pkg::INFO_FIELD_W-1:0] info,
                          output table_result_t r);
    int  hit;
    int  free;
    logic [vkt_pkg::VER_FIELD_W-1:0] lv;
    hit = -1;
    free = -1;
    r = '0;
    r.status = vkt_pkg::ST_OK;
    for (int i = SLOTS - 1; i >= 0; i--) begin
      if (slot_used[i] && slot_key[i] == k) hit = i;
      if (!slot_used[i]) free = i;
    end
    if (op == vkt_pkg::OP_INSERT) begin
      if (hit >= 0) begin
        lv = slot_top[hit];
        if (lv >= DEPTH) begin
          r.status = vkt_pkg::ST_FULL;
          r.ver = lv;
        end else begin
          lv = lv + 4'd1;
          slot_top[hit] = lv;
          ver_info[hit][lv-1] = info;
          ver_busy[hit][lv-1] = 1'b1;
          r.ver = lv;
        end
      end else if (free < 0) begin
        r.status = vkt_pkg::ST_FULL;
      end else begin
        slot_used[free] = 1'b1;
        slot_key[free] = k;
        slot_top[free] = 4'd1;
        ver_info[free][0] = info;
        ver_busy[free][0] = 1'b1;
        r.ver = 4'd1;
      end
    end else if (hit < 0) begin
      r.status = vkt_pkg::ST_NOKEY;
    end else begin
      lv = slot_top[hit];
      r.ver = lv;
      if (op == vkt_pkg::OP_FETCH) begin
        if (v >= 1 && v <= lv) begin
          r.info = ver_info[hit][v-1];
          r.busy = ver_busy[hit][v-1];
        end else begin
          r.status = vkt_pkg::ST_NOVER;
        end
      end else if (op == vkt_pkg::OP_DELETE) begin
        if (lv >= 1 && lv <= DEPTH) ver_busy[hit][lv-1] = 1'b0;
      end
    end
  endtask

  task automatic compare_field(input string name, input logic [31:0] exp_v,
                               input logic [31:0] act_v);
    if (exp_v !== act_v) begin
      $display("%0t: %s mismatch, expected %0h, got %0h", $time, name, exp_v, act_v);
      errors++;
    end
  endtask

  always @(posedge clk) begin
    table_result_t want;
    table_result_t got;
    if (!rst_n) begin
      foreach (slot_used[i]) slot_used[i] = 1'b0;
      awaited_q.delete();
      errors = 0;
    end else begin
      if (out_tvalid && out_tready) begin
        got.status = vkt_pkg::status_t'(out_tdata[1:0]);
        got.ver = out_tdata[5:2];
        got.info = out_tdata[21:6];
        got.busy = out_tdata[22];
        if (awaited_q.size() == 0) begin
          $display("%0t: unexpected result transaction, expected none, got %0h", $time,
                   out_tdata);
          errors++;
        end else begin
          want = awaited_q.pop_front();
          compare_field("status", 32'(want.status), 32'(got.status));
          compare_field("version_out", 32'(want.ver), 32'(got.ver));
          compare_field("info_out", 32'(want.info), 32'(got.info));
          compare_field("busy_out", 32'(want.busy), 32'(got.busy));
        end
      end
      if (in_tvalid && in_tready) begin
        apply_op(vkt_pkg::op_t'(in_tdata[1:0]), in_tdata[33:2], in_tdata[37:34],
                 in_tdata[53:38], want);
        awaited_q.push_back(want);
      end
    end
    pending <= awaited_q.size();
  end

endmodule

// ===== test/tb_versioned_key_table.sv =====
module tb_versioned_key_table;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int RANDOM_OPS  = 1550;
  localparam int QUIET_LIMIT = 2000;
  localparam int POOL_SIZE   = 22;

  logic                           clk = 1'b0;
  logic                           rst_n = 1'b0;
  logic                           in_tvalid = 1'b0;
  logic                           in_tready;
  logic [vkt_pkg::IN_DATA_W-1:0]  in_tdata = '0;
  logic                           out_tvalid;
  logic                           out_tready = 1'b0;
  logic [vkt_pkg::OUT_DATA_W-1:0] out_tdata;
  logic                           calm = 1'b0;
  int                             errors;
  int                             pending;
  int                             quiet = 0;
  logic [vkt_pkg::KEY_W-1:0]      key_pool [POOL_SIZE];

  always begin
    clk = 1'b1;
    #1;
    clk = 1'b0;
    #1;
  end

  versioned_key_table DUT (
    .clk(clk),
    .rst_n(rst_n),
    .in_tvalid(in_tvalid),
    .in_tready(in_tready),
    .in_tdata(in_tdata),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata(out_tdata)
  );

  vkt_checker table_mon (
    .clk(clk),
    .rst_n(rst_n),
    .in_tvalid(in_tvalid),
    .in_tready(in_tready),
    .in_tdata(in_tdata),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata(out_tdata),
    .errors(errors),
    .pending(pending)
  );

  always @(posedge clk) begin
    out_tready <= calm ? 1'b1 : ($urandom_range(0, 99) >= 34);
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
        quiet <= 0;
      end else begin
        quiet <= quiet + 1;
      end
      if (quiet >= QUIET_LIMIT) begin
        $display("TB_ERROR");
        $finish;
      end
    end
  end

  task automatic send_op(input vkt_pkg::op_t op, input logic [vkt_pkg::KEY_W-1:0] k,
                         input logic [vkt_pkg::VER_FIELD_W-1:0] v,
                         input logic [vkt_pkg::INFO_FIELD_W-1:0] info);
    if (!calm) begin
      while ($urandom_range(0, 99) < 34) begin
        in_tvalid <= 1'b0;
        @(posedge clk);
      end
    end
    in_tvalid <= 1'b1;
    in_tdata <= {2'b00, info, v, k, op};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
  endtask

  initial begin
    int  pick;
    vkt_pkg::op_t op;
    logic [vkt_pkg::KEY_W-1:0] k;
    logic [vkt_pkg::VER_FIELD_W-1:0] v;

    key_pool[0] = 32'h8000_0000;
    key_pool[1] = 32'h7fff_ffff;
    key_pool[2] = 32'h0000_0000;
    key_pool[3] = 32'hffff_ffff;
    for (int i = 4; i < POOL_SIZE; i++) key_pool[i] = $urandom;

    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // Operations on an empty table, then the field extremes and both list limits.
    send_op(vkt_pkg::OP_QUERY, 32'h0000_0000, 4'd0, 16'h0000);
    send_op(vkt_pkg::OP_FETCH, 32'hffff_ffff, 4'd1, 16'hffff);
    send_op(vkt_pkg::OP_DELETE, 32'h7fff_ffff, 4'd15, 16'h0000);
    send_op(vkt_pkg::OP_INSERT, 32'h8000_0000, 4'd0, 16'hffff);
    send_op(vkt_pkg::OP_INSERT, 32'h7fff_ffff, 4'd15, 16'h0000);
    send_op(vkt_pkg::OP_FETCH, 32'h8000_0000, 4'd1, 16'h0000);
    send_op(vkt_pkg::OP_FETCH, 32'h8000_0000, 4'd0, 16'h0000);
    send_op(vkt_pkg::OP_FETCH, 32'h8000_0000, 4'd15, 16'h0000);
    send_op(vkt_pkg::OP_DELETE, 32'h8000_0000, 4'd0, 16'h0000);
    send_op(vkt_pkg::OP_FETCH, 32'h8000_0000, 4'd1, 16'h0000);
    send_op(vkt_pkg::OP_QUERY, 32'h7fff_ffff, 4'd0, 16'h0000);
    for (int i = 0; i < vkt_pkg::VERSIONS_DEF; i++) begin
      send_op(vkt_pkg::OP_INSERT, 32'h0000_0000, 4'd0, 16'(16'h1111 * i));
    end
    send_op(vkt_pkg::OP_INSERT, 32'h0000_0000, 4'd0, 16'h5a5a);
    send_op(vkt_pkg::OP_FETCH, 32'h0000_0000, 4'd8, 16'h0000);
    send_op(vkt_pkg::OP_FETCH, 32'h0000_0000, 4'd9, 16'h0000);
    send_op(vkt_pkg::OP_DELETE, 32'h0000_0000, 4'd0, 16'h0000);
    send_op(vkt_pkg::OP_INSERT, 32'hffff_ffff, 4'd0, 16'ha5a5);

    for (int n = 0; n < RANDOM_OPS; n++) begin
      calm <= (n >= 700 && n < 950);
      pick = $urandom_range(0, 99);
      if (pick < 30) begin
        op = vkt_pkg::OP_INSERT;
      end else if (pick < 45) begin
        op = vkt_pkg::OP_QUERY;
      end else if (pick < 80) begin
        op = vkt_pkg::OP_FETCH;
      end else begin
        op = vkt_pkg::OP_DELETE;
      end
      if ($urandom_range(0, 99) < 85) begin
        k = key_pool[$urandom_range(0, POOL_SIZE - 1)];
      end else begin
        k = $urandom;
      end
      if ($urandom_range(0, 99) < 80) begin
        v = vkt_pkg::VER_FIELD_W'($urandom_range(0, 9));
      end else begin
        v = vkt_pkg::VER_FIELD_W'($urandom_range(0, 15));
      end
      send_op(op, k, v, vkt_pkg::INFO_FIELD_W'($urandom_range(0, 65535)));
    end

    in_tvalid <= 1'b0;
    calm <= 1'b0;
    do @(posedge clk); while (pending != 0);
    repeat (16) @(posedge clk);
    if (errors == 0 && pending == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
